// File: rtl/core/bsc_pkg.sv
package bsc_pkg;

  // item operation codes
  localparam logic [2:0] OP_AVAIL   = 3'd0;
  localparam logic [2:0] OP_MAX     = 3'd1;
  localparam logic [2:0] OP_ALLOC   = 3'd2;
  localparam logic [2:0] OP_REQUEST = 3'd3;
  localparam logic [2:0] OP_CHECK   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVER_MAX  = 3'd1;
  localparam logic [2:0] ST_OVER_NEED = 3'd2;
  localparam logic [2:0] ST_OVER_AVL  = 3'd3;
  localparam logic [2:0] ST_ROLLBACK  = 3'd4;
  localparam logic [2:0] ST_GRANTED   = 3'd5;
  localparam logic [2:0] ST_SAFE      = 3'd6;
  localparam logic [2:0] ST_UNSAFE    = 3'd7;

  // config register indexes
  localparam logic REG_NUM_PROC = 1'b0;
  localparam logic REG_NUM_RES  = 1'b1;

  // field widths
  localparam int OP_W     = 3;
  localparam int PROC_W   = 3;
  localparam int RES_W    = 2;
  localparam int AMOUNT_W = 12;
  localparam int STATUS_W = 3;

  // parameter defaults
  localparam int NUM_PROC_DEF    = 8;
  localparam int NUM_RES_DEF     = 4;
  localparam int AMOUNT_BITS_DEF = 12;

  typedef enum logic [1:0] {
    ADDR_ITEM,
    ADDR_REQ,
    ADDR_SCAN,
    ADDR_CLR
  } addr_sel_t;

  typedef struct packed {
    logic       in_ready;
    logic       latch;
    logic       clr;
    logic       set_avail;
    logic       set_pend;
    logic       clr_pend;
    logic       wr_item;
    logic       app_wr;
    logic       rb_wr;
    logic       rc_zero;
    logic       rc_inc;
    logic       i_inc;
    logic       scan_init;
    logic       add_work;
    logic       mark;
    logic       put;
    logic       put_seq;
    logic       e_zero;
    addr_sel_t  addr_sel;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [2:0] op;
    logic       idx_ok;
    logic       last_el;
    logic       p_in_use;
    logic       ld_refuse;
    logic       over_need;
    logic       over_avail;
    logic       rc_last;
    logic       i_end;
    logic       i_fin;
    logic       sc_fit;
    logic       k_last;
    logic       e_last;
    logic       out_free;
  } sts_t;

endpackage

// File: rtl/core/bsc_ram.sv
module bsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bsc_dp.sv
module bsc_dp #(
  parameter int NUM_PROC    = bsc_pkg::NUM_PROC_DEF,
  parameter int NUM_RES     = bsc_pkg::NUM_RES_DEF,
  parameter int AMOUNT_BITS = bsc_pkg::AMOUNT_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  bsc_pkg::cmd_t                            cmd,
  output bsc_pkg::sts_t                            sts,
  input  logic [$clog2(NUM_PROC+1)-1:0]            np,
  input  logic [$clog2(NUM_RES+1)-1:0]             nr,
  input  logic [23:0]                              s_tdata,
  input  logic                                     s_tlast,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [7:0]                               m_tdata,
  output logic                                     m_tlast
);

  localparam int PW    = NUM_PROC > 1 ? $clog2(NUM_PROC) : 1;
  localparam int RW    = NUM_RES > 1 ? $clog2(NUM_RES) : 1;
  localparam int NPW   = $clog2(NUM_PROC+1);
  localparam int NRW   = $clog2(NUM_RES+1);
  localparam int DEPTH = NUM_PROC * NUM_RES;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int AMT   = AMOUNT_BITS;
  localparam int WW    = AMOUNT_BITS + NPW;

  logic [bsc_pkg::OP_W-1:0]   it_op;
  logic [bsc_pkg::PROC_W-1:0] it_proc;
  logic [bsc_pkg::RES_W-1:0]  it_res;
  logic [AMT-1:0]             it_amt;
  logic                       it_last;

  logic [AMT-1:0] avail [NUM_RES];
  logic [AMT-1:0] pend  [NUM_RES];
  logic [WW-1:0]  work  [NUM_RES];
  logic [NUM_PROC-1:0] fin;
  logic [PW-1:0]  seq   [NUM_PROC];

  logic [RW-1:0]  rc;
  logic [NPW-1:0] i;
  logic [PW-1:0]  k;
  logic [PW-1:0]  e;
  logic [AW-1:0]  clr_cnt;

  logic [2:0]     out_status;
  logic           out_seq_valid;
  logic [2:0]     out_seq_proc;

  logic [AW-1:0]    addr;
  logic             we;
  logic [2*AMT-1:0] wdata;
  logic [2*AMT-1:0] rdata;
  logic [AMT-1:0]   mx;
  logic [AMT-1:0]   al;
  logic [AMT-1:0]   need;
  logic [RW-1:0]    res_idx;
  logic [PW-1:0]    proc_row;
  logic [PW-1:0]    scan_row;

  assign mx       = rdata[2*AMT-1:AMT];
  assign al       = rdata[AMT-1:0];
  assign need     = (mx > al) ? mx - al : '0;
  assign res_idx  = RW'(it_res);
  assign proc_row = PW'(it_proc);
  assign scan_row = i[PW-1:0];

  always_comb begin
    unique case (cmd.addr_sel)
      bsc_pkg::ADDR_ITEM: addr = AW'(proc_row * NUM_RES + res_idx);
      bsc_pkg::ADDR_REQ:  addr = AW'(proc_row * NUM_RES + rc);
      bsc_pkg::ADDR_SCAN: addr = AW'(scan_row * NUM_RES + rc);
      bsc_pkg::ADDR_CLR:  addr = clr_cnt;
      default:            addr = clr_cnt;
    endcase
  end

  always_comb begin
    we    = cmd.clr | cmd.wr_item | cmd.app_wr | cmd.rb_wr;
    wdata = '0;
    if (cmd.wr_item) begin
      wdata = (it_op == bsc_pkg::OP_MAX) ? {it_amt, al} : {mx, it_amt};
    end else if (cmd.app_wr) begin
      wdata = {mx, al + pend[rc]};
    end else if (cmd.rb_wr) begin
      wdata = {mx, al - pend[rc]};
    end
  end

  bsc_ram #(
    .WIDTH(2*AMT),
    .DEPTH(DEPTH)
  ) u_tbl (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata(wdata),
    .raddr(addr),
    .rdata(rdata)
  );

  // status back to the controller
  always_comb begin
    sts.clr_done   = (clr_cnt == AW'(DEPTH-1));
    sts.op         = it_op;
    sts.idx_ok     = (32'(it_proc) < NUM_PROC) && (32'(it_res) < NUM_RES);
    sts.last_el    = it_last;
    sts.p_in_use   = (NPW'(it_proc) < np) && (32'(it_proc) < NUM_PROC);
    sts.ld_refuse  = (it_op == bsc_pkg::OP_MAX) ? (it_amt < al) : (it_amt > mx);
    sts.over_need  = pend[rc] > need;
    sts.over_avail = pend[rc] > avail[rc];
    sts.rc_last    = (NRW'(rc) + NRW'(1)) == nr;
    sts.i_end      = i >= np;
    sts.i_fin      = fin[scan_row];
    sts.sc_fit     = WW'(need) <= work[rc];
    sts.k_last     = (NPW'(k) + NPW'(1)) == np;
    sts.e_last     = (NPW'(e) + NPW'(1)) == np;
    sts.out_free   = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      fin      <= '0;
      rc       <= '0;
      i        <= '0;
      k        <= '0;
      e        <= '0;
      for (int n = 0; n < NUM_RES; n++) begin
        avail[n] <= '0;
        pend[n]  <= '0;
      end
    end else begin
      if (cmd.clr && !sts.clr_done) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.latch) begin
        it_op   <= s_tdata[2:0];
        it_proc <= s_tdata[5:3];
        it_res  <= s_tdata[7:6];
        it_amt  <= AMT'(s_tdata[19:8]);
        it_last <= s_tlast;
      end
      if (cmd.set_avail) begin
        avail[res_idx] <= it_amt;
      end
      if (cmd.clr_pend) begin
        for (int n = 0; n < NUM_RES; n++) begin
          pend[n] <= '0;
        end
      end else if (cmd.set_pend) begin
        pend[res_idx] <= it_amt;
      end
      if (cmd.app_wr) begin
        avail[rc] <= avail[rc] - pend[rc];
      end
      if (cmd.rb_wr) begin
        avail[rc] <= avail[rc] + pend[rc];
      end
      if (cmd.rc_zero) begin
        rc <= '0;
      end else if (cmd.rc_inc) begin
        rc <= rc + RW'(1);
      end
      if (cmd.scan_init) begin
        for (int n = 0; n < NUM_RES; n++) begin
          work[n] <= WW'(avail[n]);
        end
        fin <= '0;
        i   <= '0;
        k   <= '0;
      end
      if (cmd.add_work) begin
        work[rc] <= work[rc] + WW'(al);
      end
      if (cmd.i_inc) begin
        i <= i + NPW'(1);
      end
      if (cmd.mark) begin
        fin[scan_row] <= 1'b1;
        seq[k]        <= scan_row;
        k             <= k + PW'(1);
        i             <= '0;
      end
      if (cmd.e_zero) begin
        e <= '0;
      end else if (cmd.put_seq) begin
        e <= e + PW'(1);
      end
      if (cmd.put) begin
        m_tvalid      <= 1'b1;
        out_status    <= cmd.code;
        out_seq_valid <= 1'b0;
        out_seq_proc  <= '0;
        m_tlast       <= 1'b1;
      end else if (cmd.put_seq) begin
        m_tvalid      <= 1'b1;
        out_status    <= cmd.code;
        out_seq_valid <= 1'b1;
        out_seq_proc  <= 3'(seq[e]);
        m_tlast       <= sts.e_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {1'b0, out_seq_proc, out_seq_valid, out_status};

endmodule

// File: rtl/core/bsc_ctrl.sv
module bsc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  bsc_pkg::sts_t sts,
  output bsc_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_LDWAIT,
    S_PUT1,
    S_CHK_RD,
    S_CHK_EV,
    S_APP_RD,
    S_APP_WR,
    S_RB_RD,
    S_RB_WR,
    S_SC_INIT,
    S_SC_PICK,
    S_SC_RD,
    S_SC_EV,
    S_SC_ARD,
    S_SC_ADD,
    S_SC_MARK,
    S_EMIT
  } state_t;

  state_t     state, state_next;
  logic [2:0] code, code_next;
  logic       req_mode, req_mode_next;

  always_comb begin
    state_next    = state;
    code_next     = code;
    req_mode_next = req_mode;
    cmd           = '0;
    cmd.addr_sel  = bsc_pkg::ADDR_ITEM;
    cmd.code      = code;
    unique case (state)
      S_CLR: begin
        cmd.clr      = 1'b1;
        cmd.addr_sel = bsc_pkg::ADDR_CLR;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_IDLE;
        unique case (sts.op) inside
          bsc_pkg::OP_AVAIL: begin
            if (sts.idx_ok) begin
              cmd.set_avail = 1'b1;
              code_next     = bsc_pkg::ST_OK;
              state_next    = S_PUT1;
            end
          end
          bsc_pkg::OP_MAX, bsc_pkg::OP_ALLOC: begin
            if (sts.idx_ok) state_next = S_LDWAIT;
          end
          bsc_pkg::OP_REQUEST: begin
            if (sts.idx_ok) begin
              cmd.set_pend = 1'b1;
              if (sts.last_el) begin
                if (sts.p_in_use) begin
                  cmd.rc_zero = 1'b1;
                  state_next  = S_CHK_RD;
                end else begin
                  cmd.clr_pend = 1'b1;
                  code_next    = bsc_pkg::ST_OVER_NEED;
                  state_next   = S_PUT1;
                end
              end
            end
          end
          bsc_pkg::OP_CHECK: begin
            req_mode_next = 1'b0;
            state_next    = S_SC_INIT;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LDWAIT: begin
        if (sts.ld_refuse) begin
          code_next = bsc_pkg::ST_OVER_MAX;
        end else begin
          cmd.wr_item = 1'b1;
          code_next   = bsc_pkg::ST_OK;
        end
        state_next = S_PUT1;
      end
      S_PUT1: begin
        if (sts.out_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHK_RD: begin
        cmd.addr_sel = bsc_pkg::ADDR_REQ;
        state_next   = S_CHK_EV;
      end
      S_CHK_EV: begin
        cmd.addr_sel = bsc_pkg::ADDR_REQ;
        if (sts.over_need) begin
          cmd.clr_pend = 1'b1;
          code_next    = bsc_pkg::ST_OVER_NEED;
          state_next   = S_PUT1;
        end else if (sts.over_avail) begin
          cmd.clr_pend = 1'b1;
          code_next    = bsc_pkg::ST_OVER_AVL;
          state_next   = S_PUT1;
        end else if (sts.rc_last) begin
          cmd.rc_zero = 1'b1;
          state_next  = S_APP_RD;
        end else begin
          cmd.rc_inc = 1'b1;
          state_next = S_CHK_RD;
        end
      end
      S_APP_RD: begin
        cmd.addr_sel = bsc_pkg::ADDR_REQ;
        state_next   = S_APP_WR;
      end
      S_APP_WR: begin
        cmd.addr_sel = bsc_pkg::ADDR_REQ;
        cmd.app_wr   = 1'b1;
        if (sts.rc_last) begin
          req_mode_next = 1'b1;
          state_next    = S_SC_INIT;
        end else begin
          cmd.rc_inc = 1'b1;
          state_next = S_APP_RD;
        end
      end
      S_RB_RD: begin
        cmd.addr_sel = bsc_pkg::ADDR_REQ;
        state_next   = S_RB_WR;
      end
      S_RB_WR: begin
        cmd.addr_sel = bsc_pkg::ADDR_REQ;
        cmd.rb_wr    = 1'b1;
        if (sts.rc_last) begin
          cmd.clr_pend = 1'b1;
          code_next    = bsc_pkg::ST_ROLLBACK;
          state_next   = S_PUT1;
        end else begin
          cmd.rc_inc = 1'b1;
          state_next = S_RB_RD;
        end
      end
      S_SC_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SC_PICK;
      end
      S_SC_PICK: begin
        cmd.addr_sel = bsc_pkg::ADDR_SCAN;
        if (sts.i_end) begin
          if (req_mode) begin
            cmd.rc_zero = 1'b1;
            state_next  = S_RB_RD;
          end else begin
            code_next  = bsc_pkg::ST_UNSAFE;
            state_next = S_PUT1;
          end
        end else if (sts.i_fin) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.rc_zero = 1'b1;
          state_next  = S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd.addr_sel = bsc_pkg::ADDR_SCAN;
        state_next   = S_SC_EV;
      end
      S_SC_EV: begin
        cmd.addr_sel = bsc_pkg::ADDR_SCAN;
        if (!sts.sc_fit) begin
          cmd.i_inc  = 1'b1;
          state_next = S_SC_PICK;
        end else if (sts.rc_last) begin
          cmd.rc_zero = 1'b1;
          state_next  = S_SC_ARD;
        end else begin
          cmd.rc_inc = 1'b1;
          state_next = S_SC_RD;
        end
      end
      S_SC_ARD: begin
        cmd.addr_sel = bsc_pkg::ADDR_SCAN;
        state_next   = S_SC_ADD;
      end
      S_SC_ADD: begin
        cmd.addr_sel = bsc_pkg::ADDR_SCAN;
        cmd.add_work = 1'b1;
        if (sts.rc_last) begin
          state_next = S_SC_MARK;
        end else begin
          cmd.rc_inc = 1'b1;
          state_next = S_SC_ARD;
        end
      end
      S_SC_MARK: begin
        cmd.addr_sel = bsc_pkg::ADDR_SCAN;
        cmd.mark     = 1'b1;
        if (sts.k_last) begin
          cmd.e_zero = 1'b1;
          if (req_mode) begin
            cmd.clr_pend = 1'b1;
            code_next    = bsc_pkg::ST_GRANTED;
          end else begin
            code_next = bsc_pkg::ST_SAFE;
          end
          state_next = S_EMIT;
        end else begin
          state_next = S_SC_PICK;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.put_seq = 1'b1;
          if (sts.e_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      code     <= bsc_pkg::ST_OK;
      req_mode <= 1'b0;
    end else begin
      state    <= state_next;
      code     <= code_next;
      req_mode <= req_mode_next;
    end
  end

endmodule

// File: rtl/core/bankers_safety_checker_top.sv
// Banker's algorithm safety checker. Items on the s_ side load the available
// count of each resource kind, the maximum and the allocation of each
// (process, resource) pair, collect request elements, or ask for a safety
// check. A load or request item whose index is out of range, a request
// element that is not the last, and an unknown operation give no result;
// every other item answers with one status result on the m_ side, or, for a
// granted request or a safe check, one result per process in use carrying
// the safe sequence, the last one marked by m_tlast. The max/allocation
// table sits in one single-port-read memory of NUM_PROC*NUM_RES rows; after
// reset a clearing pass writes every row, one a cycle, and no item is taken
// until it ends. Items are handled one at a time, every table access taking
// an address step and then a registered read; each pick of the safety scan
// restarts the walk at process 0 and tests one resource per read. Results
// wait in an output register, so the next item is taken while the last
// result is still unclaimed.
module bankers_safety_checker_top #(
  parameter int NUM_PROC    = bsc_pkg::NUM_PROC_DEF,
  parameter int NUM_RES     = bsc_pkg::NUM_RES_DEF,
  parameter int AMOUNT_BITS = bsc_pkg::AMOUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // operation[2:0], process[5:3], resource[7:6], amount[19:8]
  input  logic        s_tlast,  // last_element
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // status[2:0], seq_valid[3], seq_process[6:4]
  output logic        m_tlast   // last
);

  localparam int NPW = $clog2(NUM_PROC+1);
  localparam int NRW = $clog2(NUM_RES+1);

  logic [3:0]     num_processes;
  logic [2:0]     num_resources;
  logic [NPW-1:0] np;
  logic [NRW-1:0] nr;
  logic           cfg_wr;

  bsc_pkg::cmd_t cmd;
  bsc_pkg::sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register writes, index from the word address
  always_ff @(posedge clk) begin
    if (rst) begin
      num_processes <= 4'd8;
      num_resources <= 3'd4;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bsc_pkg::REG_NUM_PROC: num_processes <= pwdata[3:0];
        bsc_pkg::REG_NUM_RES:  num_resources <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bsc_pkg::REG_NUM_PROC: prdata = {28'd0, num_processes};
      bsc_pkg::REG_NUM_RES:  prdata = {29'd0, num_resources};
      default:               prdata = '0;
    endcase
  end

  // register values saturate into the supported range
  always_comb begin
    if (num_processes == 4'd0) begin
      np = NPW'(1);
    end else if (32'(num_processes) > NUM_PROC) begin
      np = NPW'(NUM_PROC);
    end else begin
      np = NPW'(num_processes);
    end
    if (num_resources == 3'd0) begin
      nr = NRW'(1);
    end else if (32'(num_resources) > NUM_RES) begin
      nr = NRW'(NUM_RES);
    end else begin
      nr = NRW'(num_resources);
    end
  end

  // sequencer: decides every step of load, request and scan
  bsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .sts     (sts),
    .cmd     (cmd)
  );

  assign s_tready = cmd.in_ready;

  // tables, vectors, counters and the result register
  bsc_dp #(
    .NUM_PROC   (NUM_PROC),
    .NUM_RES    (NUM_RES),
    .AMOUNT_BITS(AMOUNT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .np      (np),
    .nr      (nr),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule
